[sv/sensor_reply_frame_receiver_macros.svh]
// Assertion macros used by the port-level checker file of the reply frame receiver.
`ifndef SENSOR_REPLY_FRAME_RECEIVER_MACROS_SVH
`define SENSOR_REPLY_FRAME_RECEIVER_MACROS_SVH

// Property that must hold at every edge outside reset.
`define SRFR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("srfr check failed");

// When cond holds, conseq must hold in the next cycle.
`define SRFR_ASSERT_NEXT(lbl, clk, rst, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("srfr check failed");

`endif

[sv/srfr_pkg.sv]
// Constants, types and helpers of the sensor reply frame receiver.
package srfr_pkg;

  localparam int BUFFER_BYTES = 32;
  localparam int AW           = $clog2(BUFFER_BYTES);
  localparam int HDR_LEN      = 6;
  localparam int LEN_KNOWN_AT = 9;

  localparam logic [7:0] SYNC_LEAD = 8'hEF;
  localparam logic [7:0] SYNC_ADDR = 8'h01;
  localparam logic [7:0] SYNC_FILL = 8'hFF;

  localparam int POS_PID     = 6;
  localparam int POS_LEN_HI  = 7;
  localparam int POS_CONF    = 9;
  localparam int POS_WORD_HI = 10;
  localparam int POS_WORD_LO = 11;

  typedef struct packed {
    logic       done;
    logic [7:0] len;
  } srfr_done_t;

  typedef enum logic [5:0] {
    RD_IDLE = 6'b000001,
    RD_PID  = 6'b000010,
    RD_CONF = 6'b000100,
    RD_WHI  = 6'b001000,
    RD_WLO  = 6'b010000,
    RD_LAST = 6'b100000
  } srfr_rd_state_t;

  function automatic logic [7:0] sync_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = SYNC_LEAD;
      3'd1:    b = SYNC_ADDR;
      default: b = SYNC_FILL;
    endcase
    return b;
  endfunction

endpackage

[sv/srfr_if.sv]
// Valid/ready channel interfaces for received bytes and decoded replies.
interface srfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface srfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_length;
  logic [7:0]  packet_id;
  logic [7:0]  confirm_code;
  logic        success;
  logic [15:0] data_word;

  modport source (output valid, output frame_length, output packet_id,
                  output confirm_code, output success, output data_word, input ready);
  modport sink (input valid, input frame_length, input packet_id,
                input confirm_code, input success, input data_word, output ready);
endinterface

[sv/sensor_reply_frame_receiver.sv]
// Top level of the sensor reply frame receiver.
// Takes one received byte per clock cycle, hunts for the header EF 01 FF FF FF FF and
// writes each frame byte into a BUFFER_BYTES x 8 frame store RAM. The total length is
// 9 plus the big-endian length in bytes 7 and 8; a frame longer than the store is
// dropped and the hunt restarts. After the last byte of a frame a read sequencer
// fetches bytes 6, 9, 10 and 11 in turn through the single RAM read port into a
// staging register, from which the reply word is loaded into the output register. Bytes
// are taken every cycle; input is held off only while one finished reply waits in
// the staging register behind an unaccepted output word. Checksums are not checked.
module sensor_reply_frame_receiver
  import srfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  srfr_in_if.sink   rx,
  srfr_out_if.source reply
);

  logic          accept;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          hold;
  srfr_done_t    done;

  assign rx.ready = !hold;
  assign accept   = rx.valid && !hold;

  srfr_deframer u_deframer (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .done    (done)
  );

  srfr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  srfr_readout u_readout (
    .clk   (clk),
    .rst   (rst),
    .done  (done),
    .rdata (rdata),
    .raddr (raddr),
    .hold  (hold),
    .reply (reply)
  );

endmodule

[sv/srfr_ram.sv]
// Generic single write port, single read port RAM with registered read.
module srfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/srfr_deframer.sv]
// Header hunt, frame byte counting, length check and frame-end detection.
module srfr_deframer
  import srfr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output logic          we,
  output logic [AW-1:0] waddr,
  output logic [7:0]    wdata,
  output srfr_done_t    done
);

  logic [2:0] header_progress, header_progress_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] expected_total, expected_total_next;
  logic [7:0] len_hi;

  logic [2:0] hp;
  logic [7:0] cnt_inc;
  logic [7:0] total_eff;

  assign wdata = rx_byte;

  always_comb begin
    hp                   = (header_progress >= 3'(HDR_LEN)) ? 3'd0 : header_progress;
    cnt_inc              = 8'(byte_count + 8'd1);
    header_progress_next = header_progress;
    byte_count_next      = byte_count;
    expected_total_next  = expected_total;
    total_eff            = expected_total;
    we                   = 1'b0;
    waddr                = byte_count[AW-1:0];
    done                 = '0;
    if (accept) begin
      if (expected_total == 8'd0) begin
        if (rx_byte == sync_byte(hp)) begin
          we                   = 1'b1;
          waddr                = AW'(hp);
          header_progress_next = 3'(hp + 3'd1);
          if (hp == 3'(HDR_LEN - 1)) begin
            byte_count_next     = 8'(HDR_LEN);
            expected_total_next = 8'd1;
          end
        end else begin
          header_progress_next = 3'd0;
          if (rx_byte == SYNC_LEAD) begin
            we                   = 1'b1;
            waddr                = '0;
            header_progress_next = 3'd1;
          end
        end
      end else if (byte_count >= 8'(BUFFER_BYTES)) begin
        // overrun guard
        expected_total_next  = 8'd0;
        header_progress_next = 3'd0;
      end else begin
        we              = 1'b1;
        byte_count_next = cnt_inc;
        if (cnt_inc == 8'(LEN_KNOWN_AT)) begin
          if (len_hi != 8'd0 || rx_byte > 8'(BUFFER_BYTES - LEN_KNOWN_AT)) begin
            total_eff = 8'd0;
          end else begin
            total_eff = 8'(rx_byte + 8'(LEN_KNOWN_AT));
          end
          expected_total_next = total_eff;
          if (total_eff == 8'd0) begin
            header_progress_next = 3'd0;
          end
        end
        if (total_eff > 8'd1 && cnt_inc == total_eff) begin
          done.done            = 1'b1;
          done.len             = cnt_inc;
          expected_total_next  = 8'd0;
          header_progress_next = 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_progress <= '0;
      byte_count      <= '0;
      expected_total  <= '0;
    end else begin
      header_progress <= header_progress_next;
      byte_count      <= byte_count_next;
      expected_total  <= expected_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && expected_total != 8'd0 && byte_count == 8'(POS_LEN_HI)) begin
      len_hi <= rx_byte;
    end
  end

endmodule

[sv/srfr_readout.sv]
// Reply field fetch from the frame store, staging word and output register.
module srfr_readout
  import srfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  srfr_done_t        done,
  input  logic [7:0]        rdata,
  output logic [AW-1:0]     raddr,
  output logic              hold,
  srfr_out_if.source        reply
);

  srfr_rd_state_t state, state_next;

  logic [7:0]  rd_len;
  logic        stage_full;
  logic [7:0]  stage_len;
  logic [7:0]  stage_pid;
  logic [7:0]  stage_conf;
  logic [15:0] stage_word;
  logic        out_valid;
  logic        load_out;

  assign hold     = stage_full && out_valid;
  assign load_out = stage_full && (!out_valid || reply.ready);

  always_comb begin
    state_next = state;
    raddr      = AW'(POS_PID);
    case (state)
      RD_IDLE: if (done.done) begin
        state_next = RD_PID;
      end
      RD_PID: begin
        raddr      = AW'(POS_PID);
        state_next = RD_CONF;
      end
      RD_CONF: begin
        raddr      = AW'(POS_CONF);
        state_next = RD_WHI;
      end
      RD_WHI: begin
        raddr      = AW'(POS_WORD_HI);
        state_next = RD_WLO;
      end
      RD_WLO: begin
        raddr      = AW'(POS_WORD_LO);
        state_next = RD_LAST;
      end
      RD_LAST: state_next = RD_IDLE;
      default: state_next = RD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= RD_IDLE;
      stage_full <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == RD_LAST) begin
        stage_full <= 1'b1;
      end else if (load_out) begin
        stage_full <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (reply.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // fields are masked when the frame is too short to hold them
  always_ff @(posedge clk) begin
    if (state == RD_IDLE && done.done) begin
      rd_len <= done.len;
    end
    case (state)
      RD_CONF: begin
        stage_pid <= rdata;
        stage_len <= rd_len;
      end
      RD_WHI:  stage_conf <= (rd_len > 8'(POS_CONF)) ? rdata : 8'd0;
      RD_WLO:  stage_word[15:8] <= (rd_len > 8'(POS_WORD_LO)) ? rdata : 8'd0;
      RD_LAST: stage_word[7:0] <= (rd_len > 8'(POS_WORD_LO)) ? rdata : 8'd0;
      default: ;
    endcase
    if (load_out) begin
      reply.frame_length <= stage_len;
      reply.packet_id    <= stage_pid;
      reply.confirm_code <= stage_conf;
      reply.success      <= (stage_len > 8'(POS_CONF)) && (stage_conf == 8'd0);
      reply.data_word    <= stage_word;
    end
  end

  assign reply.valid = out_valid;

endmodule

[sv/srfr_checker.sv]
// Port-level checks on reply words of the sensor reply frame receiver.
`include "sensor_reply_frame_receiver_macros.svh"

module srfr_checker
  import srfr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  frame_length,
  input logic [7:0]  confirm_code,
  input logic        success,
  input logic [15:0] data_word
);

  `SRFR_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(frame_length) && $stable(data_word))
  `SRFR_ASSERT(a_len_range, clk, rst, !out_valid || (frame_length >= 8'(LEN_KNOWN_AT) && frame_length <= 8'(BUFFER_BYTES)))
  `SRFR_ASSERT(a_success, clk, rst, !out_valid || (success == (frame_length > 8'(POS_CONF) && confirm_code == 8'd0)))
  `SRFR_ASSERT(a_short_mask, clk, rst, !out_valid || frame_length > 8'(POS_WORD_LO) || (data_word == 16'd0 && (frame_length > 8'(POS_CONF) || confirm_code == 8'd0)))

endmodule

bind sensor_reply_frame_receiver srfr_checker u_srfr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (reply.valid),
  .out_ready    (reply.ready),
  .frame_length (reply.frame_length),
  .confirm_code (reply.confirm_code),
  .success      (reply.success),
  .data_word    (reply.data_word)
);

[bench/srfr_reply_checker.sv]
// Checker: predicts decoded replies from accepted bytes and compares them with the output.
module srfr_reply_checker
  import srfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  srfr_in_if   rx,
  srfr_out_if  reply,
  output int   n_fail,
  output int   n_pending
);

  typedef struct packed {
    logic [7:0]  len;
    logic [7:0]  pid;
    logic [7:0]  conf;
    logic        ok;
    logic [15:0] word;
  } srfr_reply_t;

  logic [2:0]  hdr_seen;
  logic [7:0]  stored;
  logic [7:0]  frame_total;
  logic [7:0]  frame_mem [BUFFER_BYTES];
  srfr_reply_t replies_due[$];
  srfr_reply_t due;

  task automatic report(input string msg);
    $display("[%0t] reply mismatch: %s", $time, msg);
    n_fail++;
  endtask

  task automatic restart_hunt();
    frame_total = '0;
    hdr_seen    = '0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [7:0]  want;
    int          total;
    srfr_reply_t r;
    if (frame_total == 8'd0) begin
      if (hdr_seen >= HDR_LEN) hdr_seen = '0;
      want = (hdr_seen == 3'd0) ? SYNC_LEAD : (hdr_seen == 3'd1) ? SYNC_ADDR : SYNC_FILL;
      if (b == want) begin
        hdr_seen = hdr_seen + 3'd1;
        if (hdr_seen == HDR_LEN) begin
          stored      = 8'(HDR_LEN);
          frame_total = 8'd1;
        end
      end else begin
        hdr_seen = (b == SYNC_LEAD) ? 3'd1 : 3'd0;
      end
      return;
    end
    if (stored >= BUFFER_BYTES) begin
      restart_hunt();
      return;
    end
    frame_mem[stored[AW-1:0]] = b;
    stored = stored + 8'd1;
    if (stored == LEN_KNOWN_AT) begin
      total = LEN_KNOWN_AT + {frame_mem[POS_LEN_HI], frame_mem[POS_LEN_HI + 1]};
      if (total > BUFFER_BYTES) begin
        restart_hunt();
        return;
      end
      frame_total = total[7:0];
    end
    if (frame_total <= 8'd1 || stored != frame_total) return;
    r.len  = stored;
    r.pid  = frame_mem[POS_PID];
    r.conf = '0;
    r.ok   = 1'b0;
    r.word = '0;
    if (stored > POS_CONF) begin
      r.conf = frame_mem[POS_CONF];
      r.ok   = (r.conf == 8'd0);
    end
    if (stored > POS_WORD_LO) r.word = {frame_mem[POS_WORD_HI], frame_mem[POS_WORD_LO]};
    replies_due.push_back(r);
    restart_hunt();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hdr_seen    = '0;
      stored      = '0;
      frame_total = '0;
      replies_due.delete();
    end else begin
      if (rx.valid && rx.ready) take_byte(rx.rx_byte);
      if (reply.valid && reply.ready) begin
        if (replies_due.size() == 0) begin
          report($sformatf("word with none pending: len %0d pid %02h",
                           reply.frame_length, reply.packet_id));
        end else begin
          due = replies_due.pop_front();
          if (reply.frame_length !== due.len)
            report($sformatf("frame_length %0d, want %0d", reply.frame_length, due.len));
          if (reply.packet_id !== due.pid)
            report($sformatf("packet_id %02h, want %02h", reply.packet_id, due.pid));
          if (reply.confirm_code !== due.conf)
            report($sformatf("confirm_code %02h, want %02h", reply.confirm_code, due.conf));
          if (reply.success !== due.ok)
            report($sformatf("success %b, want %b", reply.success, due.ok));
          if (reply.data_word !== due.word)
            report($sformatf("data_word %04h, want %04h", reply.data_word, due.word));
        end
      end
    end
    n_pending = replies_due.size();
  end

endmodule

[bench/tb_sensor_reply_frame_receiver.sv]
// Testbench top: byte stimulus, reply back-pressure and verdict for the reply frame receiver.
module tb_sensor_reply_frame_receiver;
  import srfr_pkg::*;

  logic clk = 1'b0;
  logic rst;
  int   n_fail;
  int   n_pending;
  int   n_sent;
  bit   burst;
  logic [7:0] tx_q[$];

  srfr_in_if  rx_ch ();
  srfr_out_if reply_ch ();

  sensor_reply_frame_receiver u_top (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_ch),
    .reply (reply_ch)
  );

  srfr_reply_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .reply     (reply_ch),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  always #5 clk = ~clk;

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    n_sent++;
  endtask

  task automatic flush_bytes();
    burst = ($urandom_range(0, 3) == 0);
    while (tx_q.size() > 0) send_byte(tx_q.pop_front());
  endtask

  task automatic queue_header();
    tx_q.push_back(SYNC_LEAD);
    tx_q.push_back(SYNC_ADDR);
    repeat (4) tx_q.push_back(SYNC_FILL);
  endtask

  // header, packet id, length field, then n_body random bytes, the first zero when conf_zero is set
  task automatic queue_frame(input logic [7:0] pid, input logic [15:0] len_field,
                             input int n_body, input bit conf_zero);
    queue_header();
    tx_q.push_back(pid);
    tx_q.push_back(len_field[15:8]);
    tx_q.push_back(len_field[7:0]);
    for (int i = 0; i < n_body; i++)
      tx_q.push_back((i == 0 && conf_zero) ? 8'h00 : 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int kind;
    int len;
    logic [15:0] big;
    rst              <= 1'b1;
    rx_ch.valid      <= 1'b0;
    rx_ch.rx_byte    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames
    queue_frame(8'h00, 16'd0, 0, 1'b0);
    queue_frame(8'hFF, 16'd1, 1, 1'b1);
    queue_frame(8'h5A, 16'd2, 2, 1'b0);
    tx_q.push_back(SYNC_LEAD);
    queue_frame(8'hA5, 16'd3, 3, 1'b0);
    queue_frame(8'h80, 16'd23, 23, 1'b1);
    queue_frame(8'h22, 16'd24, 0, 1'b0);
    queue_frame(8'h33, 16'h0100, 0, 1'b0);
    queue_frame(8'h44, 16'hFFFF, 0, 1'b0);
    tx_q.push_back(SYNC_LEAD);
    tx_q.push_back(SYNC_ADDR);
    tx_q.push_back(SYNC_FILL);
    tx_q.push_back(8'h00);
    queue_frame(8'h01, 16'd4, 4, 1'b0);
    flush_bytes();

    while (n_sent < 1000) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        if ($urandom_range(0, 7) == 0) tx_q.push_back(SYNC_LEAD);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : $urandom_range(0, 4);
        queue_frame(8'($urandom_range(0, 255)), 16'(len), len, $urandom_range(0, 2) == 0);
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 8)) tx_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 8) begin
        len = $urandom_range(1, 5);
        tx_q.push_back(SYNC_LEAD);
        if (len > 1) tx_q.push_back(SYNC_ADDR);
        for (int i = 2; i < len; i++) tx_q.push_back(SYNC_FILL);
        tx_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        big = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(24, 255))
                                          : 16'($urandom_range(256, 65535));
        queue_frame(8'($urandom_range(0, 255)), big, 0, 1'b0);
        repeat ($urandom_range(0, 5)) tx_q.push_back(8'($urandom_range(0, 255)));
      end
      flush_bytes();
    end
    rx_ch.valid <= 1'b0;

    while (n_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int stall;
    reply_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        reply_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      reply_ch.ready <= 1'b1;
      do @(posedge clk); while (!reply_ch.valid);
    end
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sensor_reply_frame_receiver.f]
+incdir+sv
sv/srfr_pkg.sv
sv/srfr_if.sv
sv/srfr_ram.sv
sv/srfr_deframer.sv
sv/srfr_readout.sv
sv/sensor_reply_frame_receiver.sv
sv/srfr_checker.sv
bench/srfr_reply_checker.sv
bench/tb_sensor_reply_frame_receiver.sv
